[design/dchs_pkg.sv]
// Shared types and constants for the distinct color hash set.
package dchs_pkg;

  // Width of the pixel field on the input channel; higher color bits read as zero.
  localparam int unsigned IN_BITS = 24;

  // Operation codes on op_i.
  localparam logic OP_CLEAR  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic start_clr;  // reset sweep counter
    logic clr_step;   // write one empty slot, advance sweep counter
    logic start_ins;  // capture color, load first slot and increment
    logic rd;         // read slot at probe index
    logic wr;         // store color at probe index
    logic adv;        // step to next probe slot
    logic res_set;    // capture result bits below
    logic res_new;
    logic res_full;
    logic load_out;   // move result into output register
  } dchs_cmd_t;

  typedef struct packed {
    logic clr_last;   // sweep is at the final slot
    logic hit;        // slot holds the color
    logic empty;      // slot is free
    logic last_probe; // increment has reached one
  } dchs_stat_t;

endpackage

[design/dchs_dp.sv]
// Datapath of the distinct color hash set: slot memory, probe registers, result registers.
module dchs_dp import dchs_pkg::*; #(
  parameter int unsigned TABLE_BITS = 12,
  parameter int unsigned PIXEL_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [PIXEL_BITS-1:0] pixel_i,
  input  dchs_cmd_t             cmd_i,
  output dchs_stat_t            stat_o,
  output logic                  is_new_o,
  output logic                  table_full_o
);

  localparam int unsigned TableSize = 1 << TABLE_BITS;

  logic [PIXEL_BITS:0]   mem [TableSize];
  logic [PIXEL_BITS:0]   rdata_q;
  logic [TABLE_BITS-1:0] idx_q, idx_d;
  logic [TABLE_BITS-1:0] incr_q, incr_d;
  logic [TABLE_BITS-1:0] clr_q, clr_d;
  logic [PIXEL_BITS-1:0] color_q, color_d;
  logic [PIXEL_BITS-1:0] color_in;
  logic [TABLE_BITS-1:0] first_idx;
  logic                  res_new_q, res_full_q;
  logic                  out_new_q, out_full_q;

  // Color bits above the input field width are forced to zero.
  if (PIXEL_BITS > IN_BITS) begin : g_wide
    assign color_in = {{(PIXEL_BITS - IN_BITS){1'b0}}, pixel_i[IN_BITS-1:0]};
  end else begin : g_narrow
    assign color_in = pixel_i;
  end

  // First probe slot: top index bits of the color, left-aligned when the color is narrower.
  if (PIXEL_BITS >= TABLE_BITS) begin : g_idx_top
    assign first_idx = color_in[PIXEL_BITS-1 -: TABLE_BITS];
  end else begin : g_idx_shift
    assign first_idx = {color_in, {(TABLE_BITS - PIXEL_BITS){1'b0}}};
  end

  always_comb begin
    idx_d   = idx_q;
    incr_d  = incr_q;
    color_d = color_q;
    clr_d   = clr_q;
    if (cmd_i.start_clr) begin
      clr_d = '0;
    end else if (cmd_i.clr_step) begin
      clr_d = clr_q + TABLE_BITS'(1);
    end
    if (cmd_i.start_ins) begin
      idx_d   = first_idx;
      incr_d  = '1;
      color_d = color_in;
    end else if (cmd_i.adv) begin
      idx_d  = idx_q + incr_q;
      incr_d = incr_q - TABLE_BITS'(2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    incr_q  <= incr_d;
    color_q <= color_d;
    if (cmd_i.res_set) begin
      res_new_q  <= cmd_i.res_new;
      res_full_q <= cmd_i.res_full;
    end
    if (cmd_i.load_out) begin
      out_new_q  <= res_new_q;
      out_full_q <= res_full_q;
    end
  end

  // Single-port slot memory: {used, color} per entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem[clr_q] <= {1'b0, {PIXEL_BITS{1'b0}}};
    end else if (cmd_i.wr) begin
      mem[idx_q] <= {1'b1, color_q};
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[idx_q];
    end
  end

  assign stat_o.clr_last   = (clr_q == '1);
  assign stat_o.hit        = rdata_q[PIXEL_BITS] && (rdata_q[PIXEL_BITS-1:0] == color_q);
  assign stat_o.empty      = !rdata_q[PIXEL_BITS];
  assign stat_o.last_probe = (incr_q == TABLE_BITS'(1));

  assign is_new_o     = out_new_q;
  assign table_full_o = out_full_q;

endmodule

[design/dchs_ctrl.sv]
// Controller of the distinct color hash set: clear sweep, probe sequence and output handshake.
module dchs_ctrl import dchs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dchs_stat_t stat_i,
  output dchs_cmd_t  cmd_o
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_RES  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       clr_res_q, clr_res_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    clr_res_d   = clr_res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          clr_res_d = 1'b0;
          if (clr_res_q) begin
            cmd_o.res_set = 1'b1;
            state_d       = ST_RES;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_INSERT) begin
            cmd_o.start_ins = 1'b1;
            state_d         = ST_RD;
          end else begin
            cmd_o.start_clr = 1'b1;
            clr_res_d       = 1'b1;
            state_d         = ST_CLR;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        priority if (stat_i.hit) begin
          cmd_o.res_set = 1'b1;
          state_d       = ST_RES;
        end else if (stat_i.empty) begin
          cmd_o.wr      = 1'b1;
          cmd_o.res_set = 1'b1;
          cmd_o.res_new = 1'b1;
          state_d       = ST_RES;
        end else if (stat_i.last_probe) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_full = 1'b1;
          state_d        = ST_RES;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = ST_RD;
        end
      end
      ST_RES: begin
        // wait until the output register is free or drains this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_res_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_res_q   <= clr_res_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[design/distinct_color_hash_set.sv]
// Top level of the distinct color hash set.
//
// Input channel (in_valid_i / in_ready_o) carries op_i and pixel_i; op 0 empties
// the table, op 1 inserts the pixel color. Output channel (out_valid_o /
// out_ready_i) returns one transfer per item: is_new_o and table_full_o.
// Items are handled one at a time. An insert makes p probes (1 to
// 2^TABLE_BITS / 2) before its result is loaded; each probe is a read and a
// compare on the single-port slot memory. A clear sweeps the memory one slot
// a cycle; its result has both bits zero. The next item can be accepted in
// the cycle after a result is loaded.
// After reset the block runs the same sweep with in_ready_o low, then accepts
// items.
// The result sits in an output register, so the next item is accepted while it
// waits; if the receiver stalls, the following result holds inside the block
// and no further item is accepted until the register drains.
module distinct_color_hash_set import dchs_pkg::*; #(
  parameter int unsigned TABLE_BITS = 12,
  parameter int unsigned PIXEL_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [PIXEL_BITS-1:0] pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_new_o,
  output logic                  table_full_o
);

  dchs_cmd_t  cmd;
  dchs_stat_t stat;

  dchs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dchs_dp #(
    .TABLE_BITS(TABLE_BITS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pixel_i     (pixel_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .is_new_o    (is_new_o),
    .table_full_o(table_full_o)
  );

endmodule

[verif/tb_distinct_color_hash_set.sv]
// Self-checking testbench for distinct_color_hash_set: in-order prediction of insert/clear.
`timescale 1ns / 1ps

module tb_distinct_color_hash_set import dchs_pkg::*;;

  localparam int unsigned TABLE_BITS = 12;
  localparam int unsigned PIXEL_BITS = 24;
  localparam int unsigned SLOTS      = 1 << TABLE_BITS;
  // Longest silent stretch: a 2048-probe insert or a sweep.
  localparam int unsigned SILENCE_LIMIT = 20000;

  typedef logic [PIXEL_BITS-1:0]            color_t;
  typedef logic [TABLE_BITS-1:0]            slot_t;
  typedef logic [PIXEL_BITS-TABLE_BITS-1:0] low_t;

  typedef struct packed {
    logic is_new;
    logic table_full;
  } outcome_t;

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  logic   op_i;
  color_t pixel_i;
  logic   out_valid_o;
  logic   out_ready_i;
  logic   is_new_o;
  logic   table_full_o;

  color_t   color_tab [SLOTS];
  bit       used_tab  [SLOTS];
  outcome_t pending_outcomes [$];
  int       mismatches   = 0;
  int       quiet_cycles = 0;
  bit       steady       = 1'b0;  // no idling on either side

  always #5 clk_i = ~clk_i;

  distinct_color_hash_set #(
    .TABLE_BITS(TABLE_BITS),
    .PIXEL_BITS(PIXEL_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_new_o    (is_new_o),
    .table_full_o(table_full_o)
  );

  // Applies one item to the local copy of the set and returns its outcome.
  function automatic outcome_t insert_or_clear(logic op, color_t px);
    outcome_t res;
    slot_t    pos;
    slot_t    stride;
    int       probe;
    res = '0;
    if (op == OP_CLEAR) begin
      foreach (used_tab[i]) used_tab[i] = 1'b0;
      return res;
    end
    pos            = px[PIXEL_BITS-1 -: TABLE_BITS];
    stride         = slot_t'(SLOTS - 1);
    res.table_full = 1'b1;
    for (probe = 0; probe < SLOTS / 2; probe++) begin
      if (!used_tab[pos]) begin
        used_tab[pos]  = 1'b1;
        color_tab[pos] = px;
        res.is_new     = 1'b1;
        res.table_full = 1'b0;
        break;
      end
      if (color_tab[pos] == px) begin
        res.table_full = 1'b0;
        break;
      end
      pos    += stride;
      stride -= slot_t'(2);
    end
    return res;
  endfunction

  // Holds valid across back-to-back items; only a gap lowers it.
  task automatic send_item(input logic op, input color_t px);
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    pixel_i    <= px;
    do @(posedge clk_i); while (!in_ready_o);
    pending_outcomes.push_back(insert_or_clear(op, px));
  endtask

  task automatic test_edge_colors();
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, '1);
    send_item(OP_INSERT, '0);                  // already present at its home slot
    send_item(OP_INSERT, color_t'(1));         // same home as zero, probes on
    send_item(OP_INSERT, color_t'(12'hFFF));
    send_item(OP_INSERT, color_t'(1));         // found after probing
    send_item(OP_INSERT, {slot_t'('1), low_t'(0)});
    send_item(OP_INSERT, color_t'(24'h5A5A5A));
    send_item(OP_CLEAR,  color_t'(24'hABCDEF)); // pixel is don't-care on a clear
    send_item(OP_INSERT, '0);                  // new again after the clear
    send_item(OP_INSERT, '1);
    send_item(OP_CLEAR,  '0);
    send_item(OP_CLEAR,  '1);
    send_item(OP_INSERT, color_t'(24'h800800));
  endtask

  // Occupies every slot of one probe sequence but the last, then overflows it.
  task automatic test_probe_exhaustion();
    slot_t  home;
    slot_t  pos;
    slot_t  stride;
    bit     visited [SLOTS];
    slot_t  chain [$];
    color_t fill [$];
    color_t home_color;
    color_t latecomer;
    color_t rival;
    color_t tmp;
    int     j;
    int     pick;
    home   = slot_t'($urandom);
    pos    = home;
    stride = slot_t'(SLOTS - 1);
    repeat (SLOTS / 2) begin
      if (!visited[pos]) begin
        visited[pos] = 1'b1;
        chain.push_back(pos);
      end
      pos    += stride;
      stride -= slot_t'(2);
    end
    void'(chain.pop_back());
    foreach (chain[i]) fill.push_back({chain[i], low_t'($urandom)});
    home_color = fill[0];
    latecomer  = home_color ^ color_t'(1);
    rival      = home_color ^ color_t'(2);
    for (j = fill.size() - 1; j > 0; j--) begin
      pick       = $urandom_range(0, j);
      tmp        = fill[j];
      fill[j]    = fill[pick];
      fill[pick] = tmp;
    end
    send_item(OP_CLEAR, color_t'($urandom));
    // each fill color lands on its own home slot
    foreach (fill[i]) begin
      send_item(OP_INSERT, fill[i]);
      if (i % 64 == 63) send_item(OP_INSERT, fill[$urandom_range(0, i)]);
    end
    send_item(OP_INSERT, latecomer);  // takes the one free slot, deep in the sequence
    send_item(OP_INSERT, rival);      // nothing free, nothing matches
    send_item(OP_INSERT, latecomer);  // match on a late probe
    send_item(OP_INSERT, rival);
    send_item(OP_INSERT, home_color);
    repeat (10) send_item(OP_INSERT, color_t'($urandom));
  endtask

  // Mostly inserts, many clustered on a few home slots, with repeats and rare clears.
  task automatic test_random_traffic(input int count);
    slot_t  hot [6];
    color_t seen [$];
    color_t px;
    int     pick;
    foreach (hot[i]) hot[i] = slot_t'($urandom);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_item(OP_CLEAR, color_t'($urandom));
        seen.delete();
      end else begin
        if (pick < 43)
          px = {hot[$urandom_range(0, 5)], low_t'($urandom)};
        else if (pick < 68 && seen.size() != 0)
          px = seen[$urandom_range(0, seen.size() - 1)];
        else if (pick < 90)
          px = color_t'($urandom);
        else
          px = {($urandom_range(0, 1) ? slot_t'('1) : slot_t'('0)), low_t'($urandom)};
        send_item(OP_INSERT, px);
        seen.push_back(px);
      end
    end
  endtask

  // Result side: random stall bursts, with occasional long free-running stretches.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!steady && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else if ($urandom_range(0, 31) == 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(16, 96)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        $error("result transfer with nothing pending: is_new %0b table_full %0b",
               is_new_o, table_full_o);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (is_new_o !== want.is_new) begin
          $error("is_new: expected %0b, actual %0b", want.is_new, is_new_o);
          mismatches++;
        end
        if (table_full_o !== want.table_full) begin
          $error("table_full: expected %0b, actual %0b", want.table_full, table_full_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= SILENCE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    op_i       <= OP_CLEAR;
    pixel_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_edge_colors();
    test_probe_exhaustion();
    test_random_traffic(300);
    steady = 1'b1;
    test_random_traffic(100);
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
